[hdl/bss_pkg.sv]
// Shared types, constants and helper functions of the boid steering block.
package bss_pkg;

  localparam int MAX_NEIGHBORS  = 4095;
  localparam int CELL_PIXELS    = 12;
  localparam int SIDE_BAND_DIV  = 3;
  localparam int FLOOR_BAND_DIV = 6;

  // Field widths
  localparam int POS_W  = 24;
  localparam int HD_W   = 16;
  localparam int CNT_W  = 12;
  localparam int FRM_W  = 7;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Internal arithmetic widths
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int CORDIC_START = 9949;
  localparam int CW     = 34;
  localparam int ZW     = 18;
  localparam int TRIG_W = 18;
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 56;
  localparam int OFFS_W = 28;
  localparam int SUMC_W = 28;
  localparam int DIST_W = 50;
  localparam int RSQ_W  = 30;
  localparam int KK_W   = 24;
  localparam int ETERM_W = 28;

  // Reciprocal multipliers for the band divisions (exact for 16-bit operands)
  localparam int DIV3_SHIFT = 17;
  localparam int DIV6_SHIFT = 18;
  localparam int DIV3_MUL = (2**DIV3_SHIFT + SIDE_BAND_DIV - 1) / SIDE_BAND_DIV;
  localparam int DIV6_MUL = (2**DIV6_SHIFT + FLOOR_BAND_DIV - 1) / FLOOR_BAND_DIV;
  localparam int RAD_UNIT_SQ = (CELL_PIXELS * 256) * (CELL_PIXELS * 256);

  // Register reset values
  localparam int RST_SEP    = 328;
  localparam int RST_ALIGN  = 98304;
  localparam int RST_COH    = 655;
  localparam int RST_EDGE   = 13107;
  localparam int RST_SPEED  = 10240;
  localparam int RST_VISION = 3;
  localparam int RST_WIDTH  = 640;
  localparam int RST_HEIGHT = 384;

  typedef enum logic [2:0] {
    REG_SEP, REG_ALIGN, REG_COH, REG_EDGE, REG_SPEED, REG_VISION, REG_WIDTH, REG_HEIGHT
  } reg_idx_t;

  typedef enum logic {CORDIC_ROTATE, CORDIC_VECTOR} cordic_mode_t;

  typedef struct packed {
    logic [9:0]       sep_w;
    logic [18:0]      align_w;
    logic [10:0]      coh_w;
    logic [15:0]      edge_w;
    logic [14:0]      speed;
    logic [15:0]      width;
    logic [15:0]      height;
    logic [15:0]      band_x;
    logic [15:0]      band_y;
    logic [15:0]      band_b;
    logic [RSQ_W-1:0] rad_sq;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    cordic_mode_t          mode;
    logic signed [CW-1:0]  vx;
    logic signed [CW-1:0]  vy;
    logic [HD_W-1:0]       angle;
  } cordic_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [ZW-1:0]  z;
  } cordic_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DX, S_DY, S_DCMP, S_NB_ROT, S_EDGE, S_K1, S_K2, S_AX, S_OX, S_AY, S_OY,
    S_SUMY, S_SOLO_ROT, S_ZCHK, S_NORM, S_VEC, S_MOVE_GO, S_MOVE_ROT, S_MX, S_MY,
    S_MFIN, S_OUT
  } state_t;

  function automatic logic signed [ZW-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      4'd0:    v = 18'sd8192;
      4'd1:    v = 18'sd4836;
      4'd2:    v = 18'sd2555;
      4'd3:    v = 18'sd1297;
      4'd4:    v = 18'sd651;
      4'd5:    v = 18'sd326;
      4'd6:    v = 18'sd163;
      4'd7:    v = 18'sd81;
      4'd8:    v = 18'sd41;
      4'd9:    v = 18'sd20;
      4'd10:   v = 18'sd10;
      4'd11:   v = 18'sd5;
      4'd12:   v = 18'sd3;
      4'd13:   v = 18'sd1;
      4'd14:   v = 18'sd1;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
    logic signed [POS_W+1:0] hi;
    logic signed [POS_W+1:0] lo;
    hi = (POS_W+2)'(2**(POS_W-1) - 1);
    lo = -(POS_W+2)'(2**(POS_W-1));
    if (v > hi) return hi[POS_W-1:0];
    else if (v < lo) return lo[POS_W-1:0];
    else return v[POS_W-1:0];
  endfunction

endpackage

[hdl/bss_in_if.sv]
// Input channel: target and neighbor candidate beats.
interface bss_in_if;
  import bss_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [HD_W-1:0]         heading;
  logic                    group_end;

  modport source (output valid, cmd, pos_x, pos_y, heading, group_end, input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, heading, group_end, output ready);
endinterface

[hdl/bss_out_if.sv]
// Output channel: steering result beats.
interface bss_out_if;
  import bss_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [HD_W-1:0]         new_heading;
  logic signed [POS_W-1:0] new_x;
  logic signed [POS_W-1:0] new_y;
  logic [FRM_W-1:0]        sprite_frame;
  logic [CNT_W-1:0]        neighbor_count;

  modport source (output valid, new_heading, new_x, new_y, sprite_frame, neighbor_count,
                  input ready);
  modport sink   (input valid, new_heading, new_x, new_y, sprite_frame, neighbor_count,
                  output ready);
endinterface

[hdl/bss_mul.sv]
// Shared signed multiplier with registered product.
module bss_mul (
  input  logic                              clk,
  input  logic signed [bss_pkg::MUL_W-1:0]  a,
  input  logic signed [bss_pkg::MUL_W-1:0]  b,
  output logic signed [bss_pkg::PROD_W-1:0] p
);
  import bss_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

[hdl/bss_cordic.sv]
// Iterative CORDIC unit, rotation and vectoring, one micro-rotation per cycle.
module bss_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  bss_pkg::cordic_req_t req,
  output bss_pkg::cordic_rsp_t rsp
);
  import bss_pkg::*;

  localparam logic signed [ZW-1:0] QUARTER = ZW'(16384);
  localparam logic signed [ZW-1:0] HALF    = ZW'(32768);
  localparam logic [STEP_W-1:0]    STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

  logic signed [CW-1:0] x, y, sx, sy;
  logic signed [ZW-1:0] z, zs, at;
  logic [STEP_W-1:0]    step;
  logic                 busy, done, flip;
  cordic_mode_t         mode;

  always_comb begin
    zs = {{(ZW-HD_W){req.angle[HD_W-1]}}, req.angle};
    sx = x >>> step;
    sy = y >>> step;
    at = atan_step(step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        mode <= req.mode;
        if (req.mode == CORDIC_ROTATE) begin
          x <= CW'(CORDIC_START);
          y <= '0;
          // fold the back half-plane onto the front one, negate at the end
          if (zs > QUARTER || zs < -QUARTER) begin
            z    <= zs[ZW-1] ? zs + HALF : zs - HALF;
            flip <= 1'b1;
          end else begin
            z    <= zs;
            flip <= 1'b0;
          end
        end else begin
          flip <= 1'b0;
          if (req.vx[CW-1]) begin
            x <= -req.vx;
            y <= -req.vy;
            z <= HALF;
          end else begin
            x <= req.vx;
            y <= req.vy;
            z <= '0;
          end
        end
      end else if (busy) begin
        if (mode == CORDIC_ROTATE) begin
          if (!z[ZW-1]) begin
            x <= x - sy; y <= y + sx; z <= z - at;
          end else begin
            x <= x + sy; y <= y - sx; z <= z + at;
          end
        end else begin
          if (!y[CW-1]) begin
            x <= x + sy; y <= y - sx; z <= z + at;
          end else begin
            x <= x - sy; y <= y + sx; z <= z - at;
          end
        end
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.x    = flip ? -x : x;
    rsp.y    = flip ? -y : y;
    rsp.z    = z;
  end
endmodule

[hdl/bss_cfg.sv]
// Configuration register file on the APB port, with derived band and radius values.
module bss_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bss_pkg::ADDR_W-1:0]  paddr,
  input  logic [bss_pkg::DATA_W-1:0]  pwdata,
  output logic [bss_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bss_pkg::cfg_t               cfg
);
  import bss_pkg::*;

  logic [9:0]  sep_w;
  logic [18:0] align_w;
  logic [10:0] coh_w;
  logic [15:0] edge_w;
  logic [14:0] speed;
  logic [2:0]  vision;
  logic [15:0] width, height;
  logic [15:0] band_x, band_y, band_b;
  logic [RSQ_W-1:0] rad_sq;
  logic [33:0] w3, h3, h6;
  logic [5:0]  vis_sq;
  logic        wr;
  reg_idx_t    idx;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_w   <= 10'(RST_SEP);
      align_w <= 19'(RST_ALIGN);
      coh_w   <= 11'(RST_COH);
      edge_w  <= 16'(RST_EDGE);
      speed   <= 15'(RST_SPEED);
      vision  <= 3'(RST_VISION);
      width   <= 16'(RST_WIDTH);
      height  <= 16'(RST_HEIGHT);
    end else if (wr) begin
      unique case (idx)
        REG_SEP:    sep_w   <= pwdata[9:0];
        REG_ALIGN:  align_w <= pwdata[18:0];
        REG_COH:    coh_w   <= pwdata[10:0];
        REG_EDGE:   edge_w  <= pwdata[15:0];
        REG_SPEED:  speed   <= pwdata[14:0];
        REG_VISION: vision  <= pwdata[2:0];
        REG_WIDTH:  width   <= pwdata[15:0];
        REG_HEIGHT: height  <= pwdata[15:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SEP:    prdata = DATA_W'(sep_w);
      REG_ALIGN:  prdata = DATA_W'(align_w);
      REG_COH:    prdata = DATA_W'(coh_w);
      REG_EDGE:   prdata = DATA_W'(edge_w);
      REG_SPEED:  prdata = DATA_W'(speed);
      REG_VISION: prdata = DATA_W'(vision);
      REG_WIDTH:  prdata = DATA_W'(width);
      REG_HEIGHT: prdata = DATA_W'(height);
      default:    prdata = '0;
    endcase
  end

  // Divide by 3 and 6 through reciprocal multiply, bands floor at 1
  assign w3     = 34'(width)  * 34'(DIV3_MUL);
  assign h3     = 34'(height) * 34'(DIV3_MUL);
  assign h6     = 34'(height) * 34'(DIV6_MUL);
  assign vis_sq = 6'(vision) * 6'(vision);

  always_ff @(posedge clk) begin
    band_x <= (w3[DIV3_SHIFT +: 16] == '0) ? 16'd1 : w3[DIV3_SHIFT +: 16];
    band_y <= (h3[DIV3_SHIFT +: 16] == '0) ? 16'd1 : h3[DIV3_SHIFT +: 16];
    band_b <= (h6[DIV6_SHIFT +: 16] == '0) ? 16'd1 : h6[DIV6_SHIFT +: 16];
    rad_sq <= RSQ_W'(RSQ_W'(vis_sq) * RSQ_W'(RAD_UNIT_SQ));
  end

  always_comb begin
    cfg.sep_w   = sep_w;
    cfg.align_w = align_w;
    cfg.coh_w   = coh_w;
    cfg.edge_w  = edge_w;
    cfg.speed   = speed;
    cfg.width   = width;
    cfg.height  = height;
    cfg.band_x  = band_x;
    cfg.band_y  = band_y;
    cfg.band_b  = band_b;
    cfg.rad_sq  = rad_sq;
  end
endmodule

[hdl/boid_steering_step.sv]
// A target beat is latched on acceptance; a neighbor beat computes the squared distance, then
// rotates through the CORDIC and adds to the sums. A group_end beat adds the edge check, the
// blend products (or the no-neighbor blend), normalize, vectoring CORDIC, move CORDIC, then the
// result beat. One beat at a time; the shared CORDIC and the single registered multiplier serialize the steps.
// Synchronous active-high reset clears the sequencer, sums, target and output valid and
// loads the register defaults.
module boid_steering_step (
  input  logic                        clk,
  input  logic                        rst,
  bss_in_if.sink                      in_ch,
  bss_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bss_pkg::ADDR_W-1:0]  paddr,
  input  logic [bss_pkg::DATA_W-1:0]  pwdata,
  output logic [bss_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bss_pkg::*;

  localparam logic [ACC_W-1:0] NORM_HI = ACC_W'(2**30);
  localparam logic [ACC_W-1:0] NORM_LO = ACC_W'(2**29);

  cfg_t        cfg;
  cordic_req_t creq;
  cordic_rsp_t crsp;
  state_t      state, state_next;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;

  // Latched beat
  logic                    it_end;
  logic signed [POS_W-1:0] it_px, it_py;
  logic [HD_W-1:0]         it_hd;

  // Group state
  logic signed [POS_W-1:0]  tgt_x, tgt_y;
  logic [HD_W-1:0]          tgt_hd;
  logic signed [OFFS_W-1:0] offs_x, offs_y;
  logic signed [SUMC_W-1:0] cos_sum, sin_sum;
  logic [CNT_W-1:0]         count;

  // Working registers
  logic [DIST_W-1:0]        dist_acc;
  logic signed [KK_W-1:0]   kk;
  logic [ETERM_W-1:0]       eterm;
  logic                     bxp, bxn, byp, byn;
  logic signed [ACC_W-1:0]  acc_x, acc_y;
  logic [HD_W-1:0]          newh;
  logic signed [TRIG_W-1:0] trig_c, trig_s;
  logic signed [POS_W-1:0]  res_x, res_y;

  // Output register
  logic                    out_valid;
  logic [HD_W-1:0]         out_hd;
  logic signed [POS_W-1:0] out_x, out_y;
  logic [FRM_W-1:0]        out_frame;
  logic [CNT_W-1:0]        out_cnt;

  // Combinational helpers
  logic signed [POS_W:0]    dx, dy;
  logic [DIST_W-1:0]        dist_sq;
  logic                     in_radius;
  logic signed [POS_W+1:0]  t26x, t26y, lo_x, hi_x, lo_y, hi_y;
  logic signed [16:0]       lim_x, lim_y;
  logic                     e_bxp, e_bxn, e_byp, e_byn, solo;
  logic signed [TRIG_W-1:0] cx, cy;
  logic [ACC_W-1:0]         ax, ay, mag;
  logic signed [ACC_W-1:0]  edge_x, edge_y, solo_x, solo_y;
  logic signed [POS_W+1:0]  step_d, moved;
  logic [24:0]              deg_prod;
  logic                     in_fire, out_load;

  bss_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  bss_cordic u_cordic (.clk, .rst, .req(creq), .rsp(crsp));

  bss_mul u_mul (.clk, .a(mul_a), .b(mul_b), .p(mul_p));

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ch.ready);

  // Offset from candidate to target, and squared distance
  assign dx        = {tgt_x[POS_W-1], tgt_x} - {it_px[POS_W-1], it_px};
  assign dy        = {tgt_y[POS_W-1], tgt_y} - {it_py[POS_W-1], it_py};
  assign dist_sq   = dist_acc + DIST_W'(mul_p);
  assign in_radius = (count < CNT_W'(MAX_NEIGHBORS)) && (dist_sq < DIST_W'(cfg.rad_sq));

  // Edge bands: push in from the near band, back from the far limit (which may go negative)
  assign t26x  = (POS_W+2)'(tgt_x);
  assign t26y  = (POS_W+2)'(tgt_y);
  assign lim_x = {1'b0, cfg.width} - {1'b0, cfg.band_x};
  assign lim_y = {1'b0, cfg.height} - {1'b0, cfg.band_b};
  assign lo_x  = {2'b00, cfg.band_x, 8'h00};
  assign hi_x  = {lim_x[16], lim_x, 8'h00};
  assign lo_y  = {2'b00, cfg.band_y, 8'h00};
  assign hi_y  = {lim_y[16], lim_y, 8'h00};
  assign e_bxp = t26x < lo_x;
  assign e_bxn = !e_bxp && (t26x > hi_x);
  assign e_byp = t26y < lo_y;
  assign e_byn = !e_byp && (t26y > hi_y);
  assign solo  = (cfg.edge_w != '0) && (e_bxp || e_bxn || e_byp || e_byn);

  assign cx = TRIG_W'(crsp.x);
  assign cy = TRIG_W'(crsp.y);

  // Edge term of the neighbor blend: sign * edge_w * n * 256
  assign edge_x = bxp ? ACC_W'({eterm, 8'h00}) : (bxn ? -ACC_W'({eterm, 8'h00}) : '0);
  assign edge_y = byp ? ACC_W'({eterm, 8'h00}) : (byn ? -ACC_W'({eterm, 8'h00}) : '0);

  // No-neighbor blend: 4 * heading vector + sign * edge_w
  assign solo_x = (ACC_W'(cx) <<< 2) +
                  (bxp ? ACC_W'(cfg.edge_w) : (bxn ? -ACC_W'(cfg.edge_w) : '0));
  assign solo_y = (ACC_W'(cy) <<< 2) +
                  (byp ? ACC_W'(cfg.edge_w) : (byn ? -ACC_W'(cfg.edge_w) : '0));

  assign ax  = acc_x[ACC_W-1] ? ACC_W'(-acc_x) : ACC_W'(acc_x);
  assign ay  = acc_y[ACC_W-1] ? ACC_W'(-acc_y) : ACC_W'(acc_y);
  assign mag = (ax > ay) ? ax : ay;

  // Rounded move step, then saturate onto the position range
  assign step_d = (POS_W+2)'((mul_p + PROD_W'(8192)) >>> 14);
  assign moved  = (POS_W+2)'(state == S_MY ? tgt_x : tgt_y) + step_d;

  // Whole degrees, then a quarter of them gives one of 90 frames
  assign deg_prod = 25'(newh) * 25'(360);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.cmd) state_next = S_DX;
          else if (in_ch.group_end) state_next = S_EDGE;
        end
      end
      S_DX:   state_next = S_DY;
      S_DY:   state_next = S_DCMP;
      S_DCMP: begin
        if (in_radius) state_next = S_NB_ROT;
        else state_next = it_end ? S_EDGE : S_IDLE;
      end
      S_NB_ROT: if (crsp.done) state_next = it_end ? S_EDGE : S_IDLE;
      S_EDGE: begin
        if (count != '0) state_next = S_K1;
        else if (solo) state_next = S_SOLO_ROT;
        else state_next = S_MOVE_GO;
      end
      S_K1:   state_next = S_K2;
      S_K2:   state_next = S_AX;
      S_AX:   state_next = S_OX;
      S_OX:   state_next = S_AY;
      S_AY:   state_next = S_OY;
      S_OY:   state_next = S_SUMY;
      S_SUMY: state_next = S_ZCHK;
      S_SOLO_ROT: if (crsp.done) state_next = S_ZCHK;
      S_ZCHK: state_next = (acc_x == '0 && acc_y == '0) ? S_MOVE_GO : S_NORM;
      S_NORM: if (mag < NORM_HI && mag >= NORM_LO) state_next = S_VEC;
      S_VEC:  if (crsp.done) state_next = S_MOVE_GO;
      S_MOVE_GO:  state_next = S_MOVE_ROT;
      S_MOVE_ROT: if (crsp.done) state_next = S_MX;
      S_MX:   state_next = S_MY;
      S_MY:   state_next = S_MFIN;
      S_MFIN: state_next = S_OUT;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, CORDIC requests, ready
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    creq.start  = 1'b0;
    creq.mode   = CORDIC_ROTATE;
    creq.vx     = CW'(acc_x);
    creq.vy     = CW'(acc_y);
    creq.angle  = newh;
    in_ch.ready = (state == S_IDLE);
    unique case (state)
      S_DX: begin mul_a = MUL_W'(dx); mul_b = MUL_W'(dx); end
      S_DY: begin mul_a = MUL_W'(dy); mul_b = MUL_W'(dy); end
      S_DCMP: begin
        creq.start = in_radius;
        creq.angle = it_hd;
      end
      S_EDGE: begin
        creq.start = (count == '0) && solo;
        creq.angle = tgt_hd;
      end
      S_K1: begin mul_a = MUL_W'(cfg.sep_w);   mul_b = MUL_W'(count); end
      S_K2: begin mul_a = MUL_W'(cfg.edge_w);  mul_b = MUL_W'(count); end
      S_AX: begin mul_a = MUL_W'(cos_sum);     mul_b = MUL_W'(cfg.align_w); end
      S_OX: begin mul_a = MUL_W'(offs_x);      mul_b = MUL_W'(kk); end
      S_AY: begin mul_a = MUL_W'(sin_sum);     mul_b = MUL_W'(cfg.align_w); end
      S_OY: begin mul_a = MUL_W'(offs_y);      mul_b = MUL_W'(kk); end
      S_NORM: begin
        creq.start = (mag < NORM_HI) && (mag >= NORM_LO);
        creq.mode  = CORDIC_VECTOR;
      end
      S_MOVE_GO: creq.start = 1'b1;
      S_MX: begin mul_a = MUL_W'(cfg.speed); mul_b = MUL_W'(trig_c); end
      S_MY: begin mul_a = MUL_W'(cfg.speed); mul_b = MUL_W'(trig_s); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Group state: target load, neighbor sums, clear on target and after a result
  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_x   <= '0;
      tgt_y   <= '0;
      tgt_hd  <= '0;
      offs_x  <= '0;
      offs_y  <= '0;
      cos_sum <= '0;
      sin_sum <= '0;
      count   <= '0;
    end else if (in_fire && !in_ch.cmd) begin
      tgt_x   <= in_ch.pos_x;
      tgt_y   <= in_ch.pos_y;
      tgt_hd  <= in_ch.heading;
      offs_x  <= '0;
      offs_y  <= '0;
      cos_sum <= '0;
      sin_sum <= '0;
      count   <= '0;
    end else if (state == S_NB_ROT && crsp.done) begin
      offs_x  <= offs_x + OFFS_W'(dx);
      offs_y  <= offs_y + OFFS_W'(dy);
      cos_sum <= cos_sum + SUMC_W'(cx);
      sin_sum <= sin_sum + SUMC_W'(cy);
      count   <= count + 1'b1;
    end else if (out_load) begin
      offs_x  <= '0;
      offs_y  <= '0;
      cos_sum <= '0;
      sin_sum <= '0;
      count   <= '0;
    end
  end

  // Datapath working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_end <= in_ch.group_end;
      it_px  <= in_ch.pos_x;
      it_py  <= in_ch.pos_y;
      it_hd  <= in_ch.heading;
    end
    case (state)
      S_DY: dist_acc <= DIST_W'(mul_p);
      S_EDGE: begin
        bxp <= e_bxp;
        bxn <= e_bxn;
        byp <= e_byp;
        byn <= e_byn;
        newh <= tgt_hd;
      end
      // kk folds separation and cohesion: cohesion sum equals minus the offset sum
      S_K2: kk    <= KK_W'(mul_p) - KK_W'(cfg.coh_w);
      S_AX: eterm <= ETERM_W'(mul_p);
      S_OX: acc_x <= ACC_W'(mul_p >>> 6) + edge_x;
      S_AY: acc_x <= acc_x + ACC_W'(mul_p);
      S_OY: acc_y <= ACC_W'(mul_p >>> 6) + edge_y;
      S_SUMY: acc_y <= acc_y + ACC_W'(mul_p);
      S_SOLO_ROT: begin
        if (crsp.done) begin
          acc_x <= solo_x;
          acc_y <= solo_y;
        end
      end
      S_NORM: begin
        // one bit a cycle until the larger component lies in [2^29, 2^30)
        if (mag >= NORM_HI) begin
          acc_x <= acc_x >>> 1;
          acc_y <= acc_y >>> 1;
        end else if (mag < NORM_LO) begin
          acc_x <= acc_x <<< 1;
          acc_y <= acc_y <<< 1;
        end
      end
      S_VEC: if (crsp.done) newh <= crsp.z[HD_W-1:0];
      S_MOVE_ROT: begin
        if (crsp.done) begin
          trig_c <= cx;
          trig_s <= cy;
        end
      end
      S_MY:   res_x <= sat_pos(moved);
      S_MFIN: res_y <= sat_pos(moved);
      default: ;
    endcase
  end

  // Output register: hold the result until the sink takes the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hd    <= newh;
      out_x     <= res_x;
      out_y     <= res_y;
      out_frame <= deg_prod[24:18];
      out_cnt   <= count;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.new_heading    = out_hd;
  assign out_ch.new_x          = out_x;
  assign out_ch.new_y          = out_y;
  assign out_ch.sprite_frame   = out_frame;
  assign out_ch.neighbor_count = out_cnt;

endmodule
